// ----- rtl/core/bpu_pkg.sv -----
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and constants of the bitmap pixel unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package bpu_pkg;

  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int MAX_HEIGHT_DEF  = 1024;
  localparam int PALETTE_ENTRIES = 16;

  localparam int SLOT_W     = 4;
  localparam int WORD_W     = 32;
  localparam int ADDR_W     = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [WORD_W-1:0] ALPHA_BITS  = 32'hFF00_0000;
  localparam logic [7:0]        NIBBLE_LOW  = 8'b0000_1111;
  localparam logic [7:0]        NIBBLE_HIGH = 8'b1111_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 4'd0,
    REG_IMAGE_HEIGHT = 4'd1,
    REG_FLIP_ROWS    = 4'd2,
    REG_PIXEL_FORMAT = 4'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_DATA = 1'b1
  } action_t;

  typedef enum logic {
    FMT_PAL4  = 1'b0,
    FMT_RGB32 = 1'b1
  } pixel_fmt_t;

  // per-item control handed from the stream tracker to the output stage
  typedef struct packed {
    pixel_fmt_t fmt;
    logic       two;    // item carries two pixels
    logic       done0;  // first pixel ends the image
    logic       done1;  // second pixel ends the image
  } item_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/bpu_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bpu_cfg_regs
// Configuration registers; stores clamped width and height, derives the
// padded byte count of a 4-bit row.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_cfg_regs #(
  parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF,
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int HW  = $clog2(MAX_HEIGHT + 1),
  localparam int RBW = WW + 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            wr_en,
  input  wire logic [bpu_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [bpu_pkg::CFG_DATA_W-1:0]  wr_data,
  output logic                                 rewind,
  output logic [WW-1:0]                        width,
  output logic [HW-1:0]                        height,
  output logic                                 flip,
  output bpu_pkg::pixel_fmt_t                  fmt,
  output logic [RBW-1:0]                       row_bytes
);

  logic [WW-1:0]       width_r;
  logic [HW-1:0]       height_r;
  logic                flip_r;
  bpu_pkg::pixel_fmt_t fmt_r;
  logic [WW-1:0]       width_in;
  logic [HW-1:0]       height_in;
  logic [RBW-1:0]      half_bytes;

  always_comb begin
    if (wr_data == '0) begin
      width_in  = WW'(1);
      height_in = HW'(1);
    end else begin
      width_in  = (32'(wr_data) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(wr_data);
      height_in = (32'(wr_data) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(wr_data);
    end
  end

  always_comb begin
    rewind = 1'b0;
    if (wr_en) begin
      unique case (bpu_pkg::cfg_reg_t'(wr_index))
        bpu_pkg::REG_IMAGE_WIDTH,
        bpu_pkg::REG_IMAGE_HEIGHT,
        bpu_pkg::REG_FLIP_ROWS,
        bpu_pkg::REG_PIXEL_FORMAT: rewind = 1'b1;
        default:                   rewind = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WW'(1);
      height_r <= HW'(1);
      flip_r   <= 1'b0;
      fmt_r    <= bpu_pkg::FMT_PAL4;
    end else if (wr_en) begin
      unique case (bpu_pkg::cfg_reg_t'(wr_index))
        bpu_pkg::REG_IMAGE_WIDTH:  width_r  <= width_in;
        bpu_pkg::REG_IMAGE_HEIGHT: height_r <= height_in;
        bpu_pkg::REG_FLIP_ROWS:    flip_r   <= wr_data[0];
        bpu_pkg::REG_PIXEL_FORMAT: fmt_r    <= bpu_pkg::pixel_fmt_t'(wr_data[0]);
        default: ;
      endcase
    end
  end

  assign half_bytes = (RBW'(width_r) + RBW'(1)) >> 1;
  assign row_bytes  = (half_bytes + RBW'(3)) & ~RBW'(3);

  assign width  = width_r;
  assign height = height_r;
  assign flip   = flip_r;
  assign fmt    = fmt_r;

endmodule

`default_nettype wire

// ----- rtl/core/bpu_palette.sv -----
// ----------------------------------------------------------------------------
// bpu_palette
// 16-entry palette memory, one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_palette (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [bpu_pkg::SLOT_W-1:0]    waddr,
  input  wire logic [bpu_pkg::WORD_W-1:0]    wdata,
  input  wire logic                          re,
  input  wire logic [bpu_pkg::SLOT_W-1:0]    raddr0,
  input  wire logic [bpu_pkg::SLOT_W-1:0]    raddr1,
  output logic [bpu_pkg::WORD_W-1:0]         rdata0,
  output logic [bpu_pkg::WORD_W-1:0]         rdata1
);

  logic [bpu_pkg::WORD_W-1:0] mem [bpu_pkg::PALETTE_ENTRIES];
  logic [bpu_pkg::WORD_W-1:0] rdata0_r;
  logic [bpu_pkg::WORD_W-1:0] rdata1_r;
  logic [bpu_pkg::WORD_W-1:0] wval;

  // entry 0 is transparent, the rest are opaque
  assign wval = (waddr == '0) ? '0 : (wdata | bpu_pkg::ALPHA_BITS);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata0_r <= mem[raddr0];
      rdata1_r <= mem[raddr1];
    end
  end

  assign rdata0 = rdata0_r;
  assign rdata1 = rdata1_r;

endmodule

`default_nettype wire

// ----- rtl/core/bpu_stream_ctrl.sv -----
// ----------------------------------------------------------------------------
// bpu_stream_ctrl
// Tracks column, row and row base address of the pixel stream and builds
// the destination address and control of each data item.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_stream_ctrl #(
  parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF,
  localparam int WW  = $clog2(MAX_WIDTH + 1),
  localparam int HW  = $clog2(MAX_HEIGHT + 1),
  localparam int RBW = WW + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          rewind_req,
  input  wire logic [WW-1:0]                 width,
  input  wire logic [HW-1:0]                 height,
  input  wire logic                          flip,
  input  wire bpu_pkg::pixel_fmt_t           fmt,
  input  wire logic [RBW-1:0]                row_bytes,
  input  wire logic                          data_go,
  output logic                               busy,
  output logic                               img_done,
  output logic                               item_emit,
  output bpu_pkg::item_ctrl_t                item_ctrl,
  output logic [bpu_pkg::ADDR_W-1:0]         item_addr
);

  localparam int XW = WW + 2;
  localparam int PW = HW + WW;

  logic [WW-1:0]               col_r, col_nxt;
  logic [HW-1:0]               row_r, row_nxt;
  logic [bpu_pkg::ADDR_W-1:0]  base_r, base_nxt;
  logic                        rewind_r;

  logic [XW-1:0]               x0;
  logic [XW-1:0]               width_x;
  logic [PW-1:0]               first_prod;
  logic [bpu_pkg::ADDR_W-1:0]  first_base;
  logic [bpu_pkg::ADDR_W-1:0]  base_step;
  logic                        final_row;
  logic                        last_px;
  logic                        nib0_ok;
  logic                        nib1_ok;
  logic                        row_end;
  logic                        finish;

  assign x0        = XW'({col_r, 1'b0});
  assign width_x   = XW'(width);
  assign final_row = ((HW+1)'(row_r) + (HW+1)'(1)) == (HW+1)'(height);
  assign last_px   = (XW'(col_r) + XW'(1)) >= width_x;
  assign nib0_ok   = x0 < width_x;
  assign nib1_ok   = (x0 + XW'(1)) < width_x;
  assign row_end   = (RBW'(col_r) + RBW'(1)) >= row_bytes;
  assign finish    = final_row && nib0_ok && ((x0 + XW'(2)) >= width_x);

  assign first_prod = PW'(height - HW'(1)) * PW'(width);
  assign first_base = flip ? bpu_pkg::ADDR_W'(first_prod) : '0;
  assign base_step  = flip ? (base_r - bpu_pkg::ADDR_W'(width))
                           : (base_r + bpu_pkg::ADDR_W'(width));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    base_nxt = base_r;
    if (data_go) begin
      if (fmt == bpu_pkg::FMT_RGB32) begin
        if (last_px) begin
          col_nxt = '0;
          row_nxt = row_r + HW'(1);
          if (!final_row) begin
            base_nxt = base_step;
          end
        end else begin
          col_nxt = col_r + WW'(1);
        end
      end else begin
        priority if (finish) begin
          col_nxt = '0;
          row_nxt = height;
        end else if (row_end) begin
          col_nxt = '0;
          row_nxt = row_r + HW'(1);
          if (!final_row) begin
            base_nxt = base_step;
          end
        end else begin
          col_nxt = col_r + WW'(1);
        end
      end
    end
  end

  always_comb begin
    item_ctrl.fmt = fmt;
    if (fmt == bpu_pkg::FMT_RGB32) begin
      item_emit       = 1'b1;
      item_ctrl.two   = 1'b0;
      item_ctrl.done0 = last_px && final_row;
      item_ctrl.done1 = 1'b0;
      item_addr       = base_r + bpu_pkg::ADDR_W'(col_r);
    end else begin
      item_emit       = nib0_ok;
      item_ctrl.two   = nib1_ok;
      item_ctrl.done0 = final_row && ((x0 + XW'(1)) == width_x);
      item_ctrl.done1 = final_row && ((x0 + XW'(2)) == width_x);
      item_addr       = base_r + bpu_pkg::ADDR_W'(x0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      base_r   <= '0;
      rewind_r <= 1'b1;
    end else if (rewind_req) begin
      col_r    <= '0;
      row_r    <= '0;
      rewind_r <= 1'b1;
    end else if (rewind_r) begin
      base_r   <= first_base;
      rewind_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      base_r <= base_nxt;
    end
  end

  assign busy     = rewind_r;
  assign img_done = row_r >= height;

endmodule

`default_nettype wire

// ----- rtl/core/bpu_out_stage.sv -----
// ----------------------------------------------------------------------------
// bpu_out_stage
// Holds one decoded item and hands its pixels, one per cycle while out_ready
// does not stall the output, to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire bpu_pkg::item_ctrl_t           ctrl,
  input  wire logic [bpu_pkg::ADDR_W-1:0]    addr,
  input  wire logic [bpu_pkg::WORD_W-1:0]    word,
  input  wire logic [bpu_pkg::WORD_W-1:0]    pal0,
  input  wire logic [bpu_pkg::WORD_W-1:0]    pal1,
  output logic                               free,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bpu_pkg::ADDR_W-1:0]         out_pixel_address,
  output logic [bpu_pkg::WORD_W-1:0]         out_pixel_color,
  output logic                               out_image_done,
  output logic                               out_run_last
);

  logic                        a_valid_r;
  logic                        a_sel_r;
  bpu_pkg::item_ctrl_t         a_ctrl_r;
  logic [bpu_pkg::ADDR_W-1:0]  a_addr_r;
  logic [bpu_pkg::WORD_W-1:0]  a_word_r;

  logic                        out_valid_r;
  logic [bpu_pkg::ADDR_W-1:0]  out_addr_r;
  logic [bpu_pkg::WORD_W-1:0]  out_color_r;
  logic                        out_done_r;
  logic                        out_last_r;

  logic                        sel_last;
  logic                        sel_done;
  logic [bpu_pkg::WORD_W-1:0]  sel_color;
  logic [bpu_pkg::ADDR_W-1:0]  sel_addr;
  logic                        out_load;
  logic                        a_drain;

  always_comb begin
    sel_last = a_sel_r || !a_ctrl_r.two;
    sel_done = a_sel_r ? a_ctrl_r.done1 : a_ctrl_r.done0;
    sel_addr = a_addr_r + bpu_pkg::ADDR_W'(a_sel_r);
    if (a_ctrl_r.fmt == bpu_pkg::FMT_RGB32) begin
      sel_color = a_word_r;
    end else begin
      sel_color = a_sel_r ? pal1 : pal0;
    end
  end

  assign out_load = a_valid_r && (!out_valid_r || out_ready);
  assign a_drain  = out_load && sel_last;
  assign free     = !a_valid_r || a_drain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      a_sel_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        a_valid_r <= 1'b1;
        a_sel_r   <= 1'b0;
      end else if (a_drain) begin
        a_valid_r <= 1'b0;
      end else if (out_load) begin
        a_sel_r <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      a_ctrl_r <= ctrl;
      a_addr_r <= addr;
      a_word_r <= word;
    end
    if (out_load) begin
      out_addr_r  <= sel_addr;
      out_color_r <= sel_color;
      out_done_r  <= sel_done;
      out_last_r  <= sel_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_image_done    = out_done_r;
  assign out_run_last      = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/core/bmp_pixel_unpacker.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_unpacker
// Unpacks 4-bit palette or 32-bit direct bitmap pixel data into
// destination-addressed 32-bit pixels.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    action, palette_slot, data_word
//   out_     output     out_valid / out_ready  pixel_address, pixel_color,
//                                              image_done, run_last
//   cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item is taken per cycle when the output drains; a 4-bit byte of two
// pixels holds the input until its second pixel is loaded, as the output
// register moves one pixel per cycle when not stalled. An item passes the
// item register, then the output register, to out_valid. Palette reads
// are registered at accept; the row base is updated by add or subtract of
// the width, only a rewind uses the multiplier. Reset and a write to any
// of the four configuration registers rewind the stream; in_ready is low
// after either while the first row base is computed. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_pixel_unpacker #(
  parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_action,
  input  wire logic [bpu_pkg::SLOT_W-1:0]    in_palette_slot,
  input  wire logic [bpu_pkg::WORD_W-1:0]    in_data_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [bpu_pkg::ADDR_W-1:0]         out_pixel_address,
  output logic [bpu_pkg::WORD_W-1:0]         out_pixel_color,
  output logic                               out_image_done,
  output logic                               out_run_last,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpu_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RBW = WW + 1;

  logic                        rewind;
  logic [WW-1:0]               width;
  logic [HW-1:0]               height;
  logic                        flip;
  bpu_pkg::pixel_fmt_t         fmt;
  logic [RBW-1:0]              row_bytes;

  logic                        accept;
  logic                        data_go;
  logic                        pal_we;
  logic                        busy;
  logic                        img_done;
  logic                        item_emit;
  bpu_pkg::item_ctrl_t         item_ctrl;
  logic [bpu_pkg::ADDR_W-1:0]  item_addr;
  logic                        stage_free;
  logic [bpu_pkg::WORD_W-1:0]  pal0;
  logic [bpu_pkg::WORD_W-1:0]  pal1;
  logic [bpu_pkg::SLOT_W-1:0]  nib_hi;
  logic [bpu_pkg::SLOT_W-1:0]  nib_lo;

  assign cfg_ready = 1'b1;
  assign in_ready  = stage_free && !busy;
  assign accept    = in_valid && in_ready;
  assign pal_we    = accept && (bpu_pkg::action_t'(in_action) == bpu_pkg::ACT_LOAD);
  assign data_go   = accept && (bpu_pkg::action_t'(in_action) == bpu_pkg::ACT_DATA)
                     && !img_done;

  assign nib_hi = bpu_pkg::SLOT_W'((in_data_word[7:0] & bpu_pkg::NIBBLE_HIGH) >> 4);
  assign nib_lo = bpu_pkg::SLOT_W'(in_data_word[7:0] & bpu_pkg::NIBBLE_LOW);

  bpu_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cfg_valid && cfg_ready),
    .wr_index  (cfg_index),
    .wr_data   (cfg_data),
    .rewind    (rewind),
    .width     (width),
    .height    (height),
    .flip      (flip),
    .fmt       (fmt),
    .row_bytes (row_bytes)
  );

  bpu_palette u_pal (
    .clk    (clk),
    .we     (pal_we),
    .waddr  (in_palette_slot),
    .wdata  (in_data_word),
    .re     (data_go),
    .raddr0 (nib_hi),
    .raddr1 (nib_lo),
    .rdata0 (pal0),
    .rdata1 (pal1)
  );

  bpu_stream_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stream (
    .clk        (clk),
    .rst_n      (rst_n),
    .rewind_req (rewind),
    .width      (width),
    .height     (height),
    .flip       (flip),
    .fmt        (fmt),
    .row_bytes  (row_bytes),
    .data_go    (data_go),
    .busy       (busy),
    .img_done   (img_done),
    .item_emit  (item_emit),
    .item_ctrl  (item_ctrl),
    .item_addr  (item_addr)
  );

  bpu_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (data_go && item_emit),
    .ctrl              (item_ctrl),
    .addr              (item_addr),
    .word              (in_data_word),
    .pal0              (pal0),
    .pal1              (pal1),
    .free              (stage_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_image_done    (out_image_done),
    .out_run_last      (out_run_last)
  );

endmodule

`default_nettype wire

// ----- rtl/core/bpu_checker.sv -----
// ----------------------------------------------------------------------------
// bpu_checker
// Port-level checks of the bitmap pixel unpacker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpu_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_ready,
  input wire logic                             out_valid,
  input wire logic                             out_ready,
  input wire logic [bpu_pkg::ADDR_W-1:0]       out_pixel_address,
  input wire logic [bpu_pkg::WORD_W-1:0]       out_pixel_color,
  input wire logic                             out_image_done,
  input wire logic                             out_run_last,
  input wire logic                             cfg_valid,
  input wire logic                             cfg_ready,
  input wire logic [bpu_pkg::CFG_IDX_W-1:0]    cfg_index
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_pixel_address) && $stable(out_pixel_color))
    else $error("stalled output item changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_image_done |-> out_run_last)
    else $error("image end not on last pixel of item");

  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("second pixel of item not presented next cycle");

  a_rewind_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
      (cfg_index == bpu_pkg::REG_IMAGE_WIDTH  || cfg_index == bpu_pkg::REG_IMAGE_HEIGHT ||
       cfg_index == bpu_pkg::REG_FLIP_ROWS    || cfg_index == bpu_pkg::REG_PIXEL_FORMAT)
      |=> !in_ready)
    else $error("input taken during stream rewind");

endmodule

bind bmp_pixel_unpacker bpu_checker u_bpu_checker (.*);

`default_nettype wire
